FILE: rtl/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
package wsd_pkg;

  localparam int LEN_W = 17;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd65536;

  localparam logic [2:0] PH_BYTE0   = 3'd0;
  localparam logic [2:0] PH_BYTE1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_ERROR   = 3'd5;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [1:0] MASK_LAST_IDX = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       frame_opcode;
    logic             fin_flag;
    logic             was_masked;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       data_out;
    logic             last;
  } res_t;

endpackage

FILE: rtl/wsd_channels.sv
// valid/ready channel interfaces for received bytes and parse results
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_result_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [3:0]               frame_opcode;
  logic                     fin_flag;
  logic                     was_masked;
  logic [wsd_pkg::LEN_W-1:0] payload_len;
  logic [7:0]               data_out;
  logic                     last;

  modport source (output valid, output kind, output frame_opcode, output fin_flag,
                  output was_masked, output payload_len, output data_out, output last,
                  input ready);
  modport sink (input valid, input kind, input frame_opcode, input fin_flag,
                input was_masked, input payload_len, input data_out, input last,
                output ready);
endinterface

FILE: rtl/websocket_frame_deframer_unit.sv
// top level of the websocket frame deframer
// Takes one received byte per transfer on stream and parses websocket frames: a header
// result once the header and any mask key are in, then one unmasked result per payload
// byte with last set on the final one (or on the header of an empty frame). A frame
// longer than max length gives an error result, after which all bytes are dropped until
// reset. One byte is taken every cycle unless result.ready stalls the result register;
// result.valid rises after the byte passes the input register, the combinational parse
// and the result register. stream.ready follows result.ready combinationally through it.
// The user must write the length limit (cfg_wr_en/cfg_wr_data) only while idle; not enforced.
module websocket_frame_deframer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [wsd_pkg::LEN_W-1:0] cfg_wr_data,
  wsd_byte_if.sink                  stream,
  wsd_result_if.source              result
);

  logic          advance;
  logic          byte_valid;
  logic [7:0]    byte_data;
  logic          res_valid;
  wsd_pkg::res_t res;
  wsd_pkg::res_t out_res;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (stream.valid),
    .up_byte    (stream.in_byte),
    .up_ready   (stream.ready),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .byte_data   (byte_data),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .down_ready (result.ready),
    .advance    (advance),
    .out_valid  (result.valid),
    .out_res    (out_res)
  );

  assign result.kind         = out_res.kind;
  assign result.frame_opcode = out_res.frame_opcode;
  assign result.fin_flag     = out_res.fin_flag;
  assign result.was_masked   = out_res.was_masked;
  assign result.payload_len  = out_res.payload_len;
  assign result.data_out     = out_res.data_out;
  assign result.last         = out_res.last;

endmodule

FILE: rtl/wsd_in_stage.sv
// input register holding one received byte
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  input  logic [7:0] up_byte,
  output logic       up_ready,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  assign up_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (up_ready) begin
      byte_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      byte_data <= up_byte;
    end
  end

endmodule

FILE: rtl/wsd_parser.sv
// frame header state machine, length check and payload unmasking
module wsd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [wsd_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      byte_valid,
  input  logic [7:0]                byte_data,
  input  logic                      advance,
  output logic                      res_valid,
  output wsd_pkg::res_t             res
);

  logic [wsd_pkg::LEN_W-1:0] max_len;
  logic [2:0]                phase, phase_next;
  logic [wsd_pkg::LEN_W-1:0] len_lo, len_lo_next;
  logic                      len_ovf, len_ovf_next;
  logic [3:0]                ext_left, ext_left_next;
  logic [31:0]               key_word, key_word_next;
  logic [wsd_pkg::LEN_W-1:0] payload_left, payload_left_next;
  logic [1:0]                mask_idx, mask_idx_next;
  logic [3:0]                held_opcode, held_opcode_next;
  logic                      held_fin, held_fin_next;
  logic                      held_masked, held_masked_next;

  logic       fire;
  logic       emit;
  logic       after_len;
  logic       finish;
  logic       over;
  logic [7:0] key_byte;

  assign fire = byte_valid && advance;
  assign res_valid = byte_valid && emit;

  always_comb begin
    phase_next        = phase;
    len_lo_next       = len_lo;
    len_ovf_next      = len_ovf;
    ext_left_next     = ext_left;
    key_word_next     = key_word;
    payload_left_next = payload_left;
    mask_idx_next     = mask_idx;
    held_opcode_next  = held_opcode;
    held_fin_next     = held_fin;
    held_masked_next  = held_masked;
    emit      = 1'b0;
    after_len = 1'b0;
    finish    = 1'b0;
    over      = 1'b0;
    key_byte  = 8'd0;
    res.kind     = wsd_pkg::KIND_HEADER;
    res.data_out = 8'd0;
    res.last     = 1'b0;

    case (phase)
      wsd_pkg::PH_BYTE0: begin
        held_opcode_next = byte_data[3:0];
        held_fin_next    = byte_data[7];
        phase_next       = wsd_pkg::PH_BYTE1;
      end
      wsd_pkg::PH_BYTE1: begin
        held_masked_next = byte_data[7];
        len_lo_next      = '0;
        len_ovf_next     = 1'b0;
        if (byte_data[6:0] == wsd_pkg::LEN7_EXT16) begin
          ext_left_next = wsd_pkg::EXT16_BYTES;
          phase_next    = wsd_pkg::PH_EXTLEN;
        end else if (byte_data[6:0] == wsd_pkg::LEN7_EXT64) begin
          ext_left_next = wsd_pkg::EXT64_BYTES;
          phase_next    = wsd_pkg::PH_EXTLEN;
        end else begin
          len_lo_next = wsd_pkg::LEN_W'(byte_data[6:0]);
          after_len   = 1'b1;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        len_lo_next   = {len_lo[wsd_pkg::LEN_W-9:0], byte_data};
        len_ovf_next  = len_ovf || (|len_lo[wsd_pkg::LEN_W-1:wsd_pkg::LEN_W-8]);
        ext_left_next = 4'(ext_left - 4'd1);
        after_len     = (ext_left_next == 4'd0);
      end
      wsd_pkg::PH_MASK: begin
        key_word_next = {key_word[23:0], byte_data};
        if (mask_idx != wsd_pkg::MASK_LAST_IDX) begin
          mask_idx_next = 2'(mask_idx + 2'd1);
        end else begin
          finish = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        case (mask_idx)
          2'd0: key_byte = key_word[31:24];
          2'd1: key_byte = key_word[23:16];
          2'd2: key_byte = key_word[15:8];
          default: key_byte = key_word[7:0];
        endcase
        if (!held_masked) begin
          key_byte = 8'd0;
        end
        mask_idx_next = 2'(mask_idx + 2'd1);
        emit          = 1'b1;
        res.kind      = wsd_pkg::KIND_PAYLOAD;
        res.data_out  = byte_data ^ key_byte;
        if (payload_left <= wsd_pkg::LEN_W'(1)) begin
          payload_left_next = '0;
          phase_next        = wsd_pkg::PH_BYTE0;
          res.last          = 1'b1;
        end else begin
          payload_left_next = wsd_pkg::LEN_W'(payload_left - wsd_pkg::LEN_W'(1));
        end
      end
      default: begin
      end
    endcase

    if (after_len) begin
      if (held_masked_next) begin
        phase_next    = wsd_pkg::PH_MASK;
        mask_idx_next = 2'd0;
        key_word_next = 32'd0;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      over = len_ovf_next || (len_lo_next > max_len);
      emit = 1'b1;
      if (over) begin
        phase_next = wsd_pkg::PH_ERROR;
        res.kind   = wsd_pkg::KIND_ERROR;
      end else begin
        payload_left_next = len_lo_next;
        mask_idx_next     = 2'd0;
        res.kind          = wsd_pkg::KIND_HEADER;
        if (len_lo_next == '0) begin
          phase_next = wsd_pkg::PH_BYTE0;
          res.last   = 1'b1;
        end else begin
          phase_next = wsd_pkg::PH_PAYLOAD;
        end
      end
    end

    res.frame_opcode = held_opcode_next;
    res.fin_flag     = held_fin_next;
    res.was_masked   = held_masked_next;
    res.payload_len  = len_ovf_next ? wsd_pkg::LEN_SAT : len_lo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= wsd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wsd_pkg::PH_BYTE0;
      len_lo       <= '0;
      len_ovf      <= 1'b0;
      ext_left     <= 4'd0;
      key_word     <= 32'd0;
      payload_left <= '0;
      mask_idx     <= 2'd0;
      held_opcode  <= 4'd0;
      held_fin     <= 1'b0;
      held_masked  <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      len_lo       <= len_lo_next;
      len_ovf      <= len_ovf_next;
      ext_left     <= ext_left_next;
      key_word     <= key_word_next;
      payload_left <= payload_left_next;
      mask_idx     <= mask_idx_next;
      held_opcode  <= held_opcode_next;
      held_fin     <= held_fin_next;
      held_masked  <= held_masked_next;
    end
  end

endmodule

FILE: rtl/wsd_out_stage.sv
// result register toward the downstream channel
module wsd_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  wsd_pkg::res_t res,
  input  logic          down_ready,
  output logic          advance,
  output logic          out_valid,
  output wsd_pkg::res_t out_res
);

  assign advance = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

endmodule

FILE: tb/websocket_frame_deframer_unit_tb.sv
// self-checking testbench for the websocket frame deframer: directed and random byte streams
module websocket_frame_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENC_SHORT = 0;
  localparam int ENC_EXT16 = 1;
  localparam int ENC_EXT64 = 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [wsd_pkg::LEN_W-1:0] cfg_wr_data = '0;

  wsd_byte_if   bytes_ch ();
  wsd_result_if res_ch ();

  websocket_frame_deframer_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .stream(bytes_ch),
    .result(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state as seen by the predictor
  logic [2:0]                ps_phase;
  logic [63:0]               ps_len;
  logic [3:0]                ps_ext_left;
  logic [31:0]               ps_key;
  logic [wsd_pkg::LEN_W-1:0] ps_left;
  logic [1:0]                ps_key_idx;
  logic [3:0]                ps_opcode;
  logic                      ps_fin;
  logic                      ps_masked;
  logic [wsd_pkg::LEN_W-1:0] len_limit;

  logic [7:0]     tx_bytes[$];
  wsd_pkg::res_t  expected_results[$];
  wsd_pkg::res_t  seen;
  wsd_pkg::res_t  due;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned n_frames = 0;
  int unsigned n_results = 0;
  int unsigned n_headers = 0;
  int unsigned n_payload = 0;
  int unsigned n_errors = 0;
  int unsigned n_fail = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned mid_limit = 0;
  bit          fast_mode = 1'b0;

  function automatic int unsigned idle_draw();
    return fast_mode ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic last);
    wsd_pkg::res_t r;
    r.kind = kind;
    r.frame_opcode = ps_opcode;
    r.fin_flag = ps_fin;
    r.was_masked = ps_masked;
    r.payload_len = (ps_len > 64'(wsd_pkg::LEN_SAT)) ? wsd_pkg::LEN_SAT
                                                     : ps_len[wsd_pkg::LEN_W-1:0];
    r.data_out = data;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void close_header();
    if (ps_len > 64'(len_limit)) begin
      ps_phase = wsd_pkg::PH_ERROR;
      push_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b0);
    end else begin
      ps_left = ps_len[wsd_pkg::LEN_W-1:0];
      ps_key_idx = '0;
      if (ps_left == '0) begin
        ps_phase = wsd_pkg::PH_BYTE0;
        push_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b1);
      end else begin
        ps_phase = wsd_pkg::PH_PAYLOAD;
        push_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b0);
      end
    end
  endfunction

  function automatic void length_known();
    if (ps_masked) begin
      ps_phase = wsd_pkg::PH_MASK;
      ps_key_idx = '0;
      ps_key = '0;
    end else begin
      close_header();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] key_byte;
    case (ps_phase)
      wsd_pkg::PH_BYTE0: begin
        ps_opcode = b[3:0];
        ps_fin = b[7];
        ps_phase = wsd_pkg::PH_BYTE1;
      end
      wsd_pkg::PH_BYTE1: begin
        ps_masked = b[7];
        ps_len = '0;
        if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
          ps_ext_left = wsd_pkg::EXT16_BYTES;
          ps_phase = wsd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
          ps_ext_left = wsd_pkg::EXT64_BYTES;
          ps_phase = wsd_pkg::PH_EXTLEN;
        end else begin
          ps_len = 64'(b[6:0]);
          length_known();
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        ps_len = {ps_len[55:0], b};
        ps_ext_left = ps_ext_left - 1'b1;
        if (ps_ext_left == '0) length_known();
      end
      wsd_pkg::PH_MASK: begin
        ps_key = {ps_key[23:0], b};
        if (ps_key_idx != wsd_pkg::MASK_LAST_IDX) ps_key_idx = ps_key_idx + 1'b1;
        else close_header();
      end
      wsd_pkg::PH_PAYLOAD: begin
        key_byte = ps_masked ? ps_key[8*(3-ps_key_idx) +: 8] : 8'h00;
        ps_key_idx = ps_key_idx + 1'b1;
        if (ps_left <= 1) begin
          ps_left = '0;
          ps_phase = wsd_pkg::PH_BYTE0;
          push_result(wsd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b1);
        end else begin
          ps_left = ps_left - 1'b1;
          push_result(wsd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void queue_frame(logic [3:0] op, logic fin, logic masked,
                                      logic [63:0] len, int enc, int unsigned n_data);
    push_byte({fin, 3'($urandom_range(0, 7)), op});
    case (enc)
      ENC_SHORT: push_byte({masked, len[6:0]});
      ENC_EXT16: begin
        push_byte({masked, wsd_pkg::LEN7_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, wsd_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) repeat (4) push_byte(8'($urandom_range(0, 255)));
    repeat (n_data) push_byte(8'($urandom_range(0, 255)));
    n_frames++;
  endfunction

  // well-formed frames that stay within the current length limit
  function automatic void random_frames(int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned cap;
    int unsigned len;
    int unsigned pick;
    int          enc;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      cap = (len_limit < 300) ? len_limit : 300;
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, (cap < 16) ? cap : 16);
      else if (pick < 8) len = $urandom_range(0, cap);
      else if (pick == 8) len = cap;
      else len = $urandom_range(125, 127);
      if (len > len_limit) len = cap;
      if (len <= 125 && $urandom_range(0, 1) == 0) enc = ENC_SHORT;
      else if (len <= 65535 && $urandom_range(0, 1) == 0) enc = ENC_EXT16;
      else enc = ENC_EXT64;
      queue_frame(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 64'(len), enc, len);
    end
  endfunction

  function automatic void note_mismatch(string what, wsd_pkg::res_t want,
                                        wsd_pkg::res_t got);
    n_fail++;
    if (n_fail <= MAX_REPORTS) begin
      $display("%0t %s: expected kind=%0d op=%h fin=%b masked=%b len=%0d data=%h last=%b",
               $realtime, what, want.kind, want.frame_opcode, want.fin_flag, want.was_masked,
               want.payload_len, want.data_out, want.last);
      $display("    got kind=%0d op=%h fin=%b masked=%b len=%0d data=%h last=%b",
               got.kind, got.frame_opcode, got.fin_flag, got.was_masked,
               got.payload_len, got.data_out, got.last);
    end
  endfunction

  task automatic drain();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [wsd_pkg::LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_limit = v;
  endtask

  // byte sender
  always @(posedge clk) begin
    if (rst) begin
      bytes_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (bytes_ch.valid && bytes_ch.ready) begin
        deframe_byte(bytes_ch.in_byte);
        bytes_taken++;
      end
      if (!bytes_ch.valid || bytes_ch.ready) begin
        if (tx_gap != 0) begin
          bytes_ch.valid <= 1'b0;
          tx_gap--;
        end else if (tx_bytes.size() != 0) begin
          bytes_ch.valid <= 1'b1;
          bytes_ch.in_byte <= tx_bytes.pop_front();
          tx_gap = idle_draw();
        end else begin
          bytes_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        seen.kind = res_ch.kind;
        seen.frame_opcode = res_ch.frame_opcode;
        seen.fin_flag = res_ch.fin_flag;
        seen.was_masked = res_ch.was_masked;
        seen.payload_len = res_ch.payload_len;
        seen.data_out = res_ch.data_out;
        seen.last = res_ch.last;
        case (seen.kind)
          wsd_pkg::KIND_HEADER: n_headers++;
          wsd_pkg::KIND_PAYLOAD: n_payload++;
          default: n_errors++;
        endcase
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected transfer", '0, seen);
        end else begin
          due = expected_results.pop_front();
          if (seen.kind !== due.kind || seen.frame_opcode !== due.frame_opcode ||
              seen.fin_flag !== due.fin_flag || seen.was_masked !== due.was_masked ||
              seen.payload_len !== due.payload_len || seen.data_out !== due.data_out ||
              seen.last !== due.last)
            note_mismatch("mismatch", due, seen);
        end
        n_results++;
        // one long hold so the input side backs up
        rx_wait = (n_results == HOLD_AT) ? HOLD_CYCLES : idle_draw();
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      res_ch.ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("websocket_frame_deframer_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    bytes_ch.valid = 1'b0;
    bytes_ch.in_byte = '0;
    res_ch.ready = 1'b0;
    ps_phase = wsd_pkg::PH_BYTE0;
    ps_len = '0;
    ps_ext_left = '0;
    ps_key = '0;
    ps_left = '0;
    ps_key_idx = '0;
    ps_opcode = '0;
    ps_fin = 1'b0;
    ps_masked = 1'b0;
    len_limit = wsd_pkg::MAX_LEN_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty frames plain and masked, then short frames in both extended length forms
    queue_frame(4'hF, 1'b1, 1'b0, 64'd0, ENC_SHORT, 0);
    queue_frame(4'h0, 1'b0, 1'b1, 64'd0, ENC_SHORT, 0);
    queue_frame(4'hA, 1'b1, 1'b0, 64'd1, ENC_EXT16, 1);
    queue_frame(4'h5, 1'b0, 1'b1, 64'd2, ENC_EXT64, 2);
    drain();

    write_limit('0);
    fast_mode = 1'b1;
    random_frames(100);
    drain();
    fast_mode = 1'b0;

    write_limit(wsd_pkg::LEN_SAT);
    random_frames(300);
    drain();

    mid_limit = $urandom_range(1, 300);
    write_limit(wsd_pkg::LEN_W'(mid_limit));
    random_frames(300);
    drain();

    // back to the reset limit
    write_limit(wsd_pkg::MAX_LEN_RESET);
    random_frames(250);

    // oversized length with the top bit set, then bytes that must be dropped
    queue_frame(4'h1, 1'b1, 1'b1, '1, ENC_EXT64, 0);
    repeat (40) push_byte(8'($urandom_range(0, 255)));
    drain();

    n_fail += expected_results.size();
    $display("covered %0d bytes in %0d frames: %0d headers, %0d payload bytes, %0d errors",
             bytes_taken, n_frames, n_headers, n_payload, n_errors);
    $display("limits: reset, 0, %0d, %0d, 65536; one %0d-cycle receiver hold; %0d mismatches",
             wsd_pkg::LEN_SAT, mid_limit, HOLD_CYCLES, n_fail);
    if (n_fail == 0) begin
      $display("websocket_frame_deframer_unit_tb: PASS");
    end else begin
      $display("websocket_frame_deframer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: websocket_frame_deframer_unit.f
rtl/wsd_pkg.sv
rtl/wsd_channels.sv
rtl/wsd_in_stage.sv
rtl/wsd_parser.sv
rtl/wsd_out_stage.sv
rtl/websocket_frame_deframer_unit.sv
tb/websocket_frame_deframer_unit_tb.sv
